FILE: rtl/ledger_update_engine_macros.svh
// Assertion macros for the ledger update engine checker.
// Used by lue_checker.sv; no other dependencies.
`ifndef LEDGER_UPDATE_ENGINE_MACROS_SVH
`define LEDGER_UPDATE_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define LUE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lue: same-cycle check failed");

// next-cycle implication, disabled in reset
`define LUE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lue: next-cycle check failed");

// next-cycle implication, active through reset
`define LUE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lue: next-cycle check failed");

`endif

FILE: rtl/lue_pkg.sv
// Shared types and constants of the ledger update engine.
// No dependencies.
`timescale 1ns / 1ps

package lue_pkg;

  localparam int CODE_W  = 4;
  localparam int ACCT_W  = 12;
  localparam int AMT_W   = 32;
  localparam int BAL_W   = 64;
  localparam int CHUNK_W = 3;
  localparam int LEN_W   = 7;

  localparam logic [CODE_W-1:0] CODE_TRANSFER = 4'd0;
  localparam logic [CODE_W-1:0] CODE_FILL     = 4'd1;

  localparam logic KIND_TRANSFER = 1'b0;
  localparam logic KIND_FILL     = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] first_code;
    logic [ACCT_W-1:0] first_account;
    logic [CODE_W-1:0] second_code;
    logic [ACCT_W-1:0] second_value;
    logic [AMT_W-1:0]  amount;
  } in_item_t;

  typedef struct packed {
    logic                    entry_kind;
    logic [ACCT_W-1:0]       account;
    logic signed [BAL_W-1:0] balance;
    logic [CHUNK_W-1:0]      chunk;
    logic                    last;
  } out_item_t;

endpackage

FILE: rtl/lue_if.sv
// Valid/ready channel interfaces for transaction and write-set beats.
// Depends on lue_pkg.
`timescale 1ns / 1ps

interface lue_in_if import lue_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lue_out_if import lue_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ledger_update_engine.sv
// Ledger update engine: balance store, transfer and fill sequencer.
// Depends on lue_pkg and the lue_in_if / lue_out_if interfaces.
//
//   channel  dir  beat                          handshake
//   in_ch    in   one transaction               valid/ready
//   out_ch   out  one write-set entry           valid/ready
//
// Transfer: ST_RD_S, ST_WR_S write the sender entry, ST_RD_R, ST_WR_R the receiver,
//   then idle; an index at or beyond ACCOUNTS first passes ST_MOD (shared remainder).
// Fill: one entry per cycle while out_ch is not stalled, then idle after the last.
// The balance memory sets the pace: at most one read or write per step.
// After reset a clearing pass zeroes every store entry, with in_ch not ready.
// A stalled out_ch holds the sequencer before each transfer or fill store write.
`timescale 1ns / 1ps

module ledger_update_engine import lue_pkg::*; #(
  parameter int ACCOUNTS = 4096,
  parameter int CHUNKS   = 8,
  parameter int MAX_FILL = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  lue_in_if.sink    in_ch,
  lue_out_if.source out_ch
);

  localparam int AW  = $clog2(ACCOUNTS);
  localparam int XW  = (AW + 1 > ACCT_W + 1) ? AW + 1 : ACCT_W + 1;
  localparam int CSZ = (ACCOUNTS / CHUNKS == 0) ? 1 : ACCOUNTS / CHUNKS;
  localparam logic [XW-1:0] ACC_X  = XW'(ACCOUNTS);
  localparam logic [XW-1:0] FILL_X = XW'(MAX_FILL);
  localparam logic [AW-1:0] LAST_IDX = AW'(ACCOUNTS - 1);
  localparam int RCP_SH = 24;
  localparam int RCP_W  = 21;
  localparam int QP_W   = ACCT_W + RCP_W;
  localparam logic [RCP_W-1:0]  RCP    = RCP_W'((2 ** RCP_SH + ACCOUNTS - 1) / ACCOUNTS);
  localparam logic [ACCT_W-1:0] ACC_LO = ACCT_W'(ACCOUNTS);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_RD_S = 3'd3;
  localparam logic [2:0] ST_WR_S = 3'd4;
  localparam logic [2:0] ST_RD_R = 3'd5;
  localparam logic [2:0] ST_WR_R = 3'd6;
  localparam logic [2:0] ST_FILL = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [AMT_W-1:0]  amt_r, amt_nxt;
  logic [AW-1:0]     s_idx_r, s_idx_nxt;
  logic [AW-1:0]     r_idx_r, r_idx_nxt;
  logic [ACCT_W-1:0] r_raw_r, r_raw_nxt;
  logic              r_need_r, r_need_nxt;
  logic              mod_sel_r, mod_sel_nxt;
  logic              mod_ph_r, mod_ph_nxt;
  logic [ACCT_W-1:0] mod_div_r, mod_div_nxt;
  logic [ACCT_W-1:0] mod_quo_r, mod_quo_nxt;
  logic              debit_r, debit_nxt;
  logic [AW-1:0]     fill_idx_r, fill_idx_nxt;
  logic [LEN_W-1:0]  fill_cnt_r, fill_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r;
  logic [BAL_W-1:0]  rd_data_r;

  logic [BAL_W-1:0]  mem [ACCOUNTS];

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [BAL_W-1:0]  mem_wd;

  logic              out_load, out_kind, out_last;
  logic [AW-1:0]     out_acct;
  logic [BAL_W-1:0]  out_bal;
  logic [5:0]        ck_cnt;

  logic              slot_free;
  logic [QP_W-1:0]   quo_prod;
  logic [ACCT_W-1:0] quo_calc, rem_calc;
  logic [XW-1:0]     a1_x, v2_x, room_x, len_x;
  logic              exceeds;
  logic [BAL_W-1:0]  bal_calc;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // shared remainder unit: reciprocal multiply, then subtract
  assign quo_prod = QP_W'(mod_div_r) * QP_W'(RCP);
  assign quo_calc = ACCT_W'(quo_prod >> RCP_SH);
  assign rem_calc = mod_div_r - mod_quo_r * ACC_LO;

  assign a1_x   = XW'(in_ch.data.first_account);
  assign v2_x   = XW'(in_ch.data.second_value);
  assign room_x = ACC_X - a1_x;

  always_comb begin
    len_x = v2_x;
    if (len_x > FILL_X) len_x = FILL_X;
    if (len_x > room_x) len_x = room_x;
  end

  assign exceeds = !rd_data_r[BAL_W-1] && (rd_data_r[BAL_W-2:0] > (BAL_W-1)'(amt_r));

  always_comb begin
    ck_cnt = '0;
    for (int k = 1; k < CHUNKS; k++) begin
      if (32'(out_acct) >= 32'(k * CSZ)) ck_cnt = ck_cnt + 6'd1;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    amt_nxt      = amt_r;
    s_idx_nxt    = s_idx_r;
    r_idx_nxt    = r_idx_r;
    r_raw_nxt    = r_raw_r;
    r_need_nxt   = r_need_r;
    mod_sel_nxt  = mod_sel_r;
    mod_ph_nxt   = mod_ph_r;
    mod_div_nxt  = mod_div_r;
    mod_quo_nxt  = mod_quo_r;
    debit_nxt    = debit_r;
    fill_idx_nxt = fill_idx_r;
    fill_cnt_nxt = fill_cnt_r;
    mem_we       = 1'b0;
    mem_wa       = s_idx_r;
    mem_wd       = '0;
    mem_re       = 1'b0;
    mem_ra       = s_idx_r;
    out_load     = 1'b0;
    out_kind     = KIND_TRANSFER;
    out_acct     = s_idx_r;
    out_bal      = rd_data_r;
    out_last     = 1'b0;
    bal_calc     = rd_data_r;

    unique case (state_r)
      ST_CLR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_idx_r;
        mem_wd      = '0;
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == LAST_IDX) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          amt_nxt = in_ch.data.amount;
          if (in_ch.data.first_code == CODE_TRANSFER &&
              in_ch.data.second_code == CODE_TRANSFER) begin
            s_idx_nxt  = AW'(in_ch.data.first_account);
            r_idx_nxt  = AW'(in_ch.data.second_value);
            r_raw_nxt  = in_ch.data.second_value;
            r_need_nxt = (v2_x >= ACC_X);
            mod_ph_nxt = 1'b0;
            if (a1_x >= ACC_X) begin
              mod_sel_nxt = 1'b0;
              mod_div_nxt = in_ch.data.first_account;
              state_nxt   = ST_MOD;
            end else if (v2_x >= ACC_X) begin
              mod_sel_nxt = 1'b1;
              mod_div_nxt = in_ch.data.second_value;
              state_nxt   = ST_MOD;
            end else begin
              state_nxt = ST_RD_S;
            end
          end else if (in_ch.data.first_code == CODE_FILL &&
                       in_ch.data.second_code == CODE_FILL) begin
            if (a1_x < ACC_X && len_x != '0) begin
              fill_idx_nxt = AW'(in_ch.data.first_account);
              fill_cnt_nxt = LEN_W'(len_x);
              state_nxt    = ST_FILL;
            end
          end
        end
      end
      ST_MOD: begin
        mod_ph_nxt = !mod_ph_r;
        if (!mod_ph_r) begin
          mod_quo_nxt = quo_calc;
        end else if (!mod_sel_r) begin
          s_idx_nxt = AW'(rem_calc);
          if (r_need_r) begin
            mod_sel_nxt = 1'b1;
            mod_div_nxt = r_raw_r;
          end else begin
            state_nxt = ST_RD_S;
          end
        end else begin
          r_idx_nxt = AW'(rem_calc);
          state_nxt = ST_RD_S;
        end
      end
      ST_RD_S: begin
        mem_re    = 1'b1;
        mem_ra    = s_idx_r;
        state_nxt = ST_WR_S;
      end
      ST_WR_S: begin
        bal_calc = exceeds ? rd_data_r - BAL_W'(amt_r) : rd_data_r;
        if (slot_free) begin
          mem_we    = 1'b1;
          mem_wa    = s_idx_r;
          mem_wd    = bal_calc;
          debit_nxt = exceeds;
          out_load  = 1'b1;
          out_acct  = s_idx_r;
          out_bal   = bal_calc;
          state_nxt = ST_RD_R;
        end
      end
      ST_RD_R: begin
        mem_re    = 1'b1;
        mem_ra    = r_idx_r;
        state_nxt = ST_WR_R;
      end
      ST_WR_R: begin
        bal_calc = debit_r ? rd_data_r + BAL_W'(amt_r) : rd_data_r;
        if (slot_free) begin
          mem_we    = 1'b1;
          mem_wa    = r_idx_r;
          mem_wd    = bal_calc;
          out_load  = 1'b1;
          out_acct  = r_idx_r;
          out_bal   = bal_calc;
          out_last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (slot_free) begin
          mem_we       = 1'b1;
          mem_wa       = fill_idx_r;
          mem_wd       = BAL_W'(amt_r);
          out_load     = 1'b1;
          out_kind     = KIND_FILL;
          out_acct     = fill_idx_r;
          out_bal      = BAL_W'(amt_r);
          out_last     = (fill_cnt_r == LEN_W'(1));
          fill_idx_nxt = fill_idx_r + AW'(1);
          fill_cnt_nxt = fill_cnt_r - LEN_W'(1);
          if (fill_cnt_r == LEN_W'(1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amt_r      <= amt_nxt;
    s_idx_r    <= s_idx_nxt;
    r_idx_r    <= r_idx_nxt;
    r_raw_r    <= r_raw_nxt;
    r_need_r   <= r_need_nxt;
    mod_sel_r  <= mod_sel_nxt;
    mod_ph_r   <= mod_ph_nxt;
    mod_div_r  <= mod_div_nxt;
    mod_quo_r  <= mod_quo_nxt;
    debit_r    <= debit_nxt;
    fill_idx_r <= fill_idx_nxt;
    fill_cnt_r <= fill_cnt_nxt;
    if (out_load) begin
      out_r.entry_kind <= out_kind;
      out_r.account    <= ACCT_W'(out_acct);
      out_r.balance    <= out_bal;
      out_r.chunk      <= ck_cnt[CHUNK_W-1:0];
      out_r.last       <= out_last;
    end
  end

endmodule

FILE: rtl/lue_checker.sv
// Port-level checks of the ledger update engine, bound to its top level.
// Depends on lue_pkg and ledger_update_engine_macros.svh.
`timescale 1ns / 1ps
`include "ledger_update_engine_macros.svh"

module lue_checker import lue_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled result beat holds
  `LUE_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // clearing pass follows reset
  `LUE_ASSERT_NEXT_ALWAYS(a_rst_busy, clk, !rst_n, !in_ready)
  // a transfer keeps the input closed
  `LUE_ASSERT_NEXT(a_xfer_busy, clk, !rst_n, in_valid && in_ready && in_data.first_code == CODE_TRANSFER && in_data.second_code == CODE_TRANSFER, !in_ready)
  // no new item while an entry run is unfinished
  `LUE_ASSERT_SAME(a_run_busy, clk, !rst_n, out_valid && !out_data.last, !in_ready)

endmodule

bind ledger_update_engine lue_checker u_lue_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_data   (in_ch.data),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

FILE: tb/sv/tb_ledger_update_engine.sv
// Self-checking testbench for ledger_update_engine: directed transactions, then random ones,
// each checked beat by beat on the write-set channel against typed entries or a local ledger.
// Depends on lue_pkg, lue_in_if / lue_out_if and the ledger_update_engine RTL.
`timescale 1ns / 1ps

module tb_ledger_update_engine;
  import lue_pkg::*;

  localparam int LEDGER_SIZE = 4096;
  localparam int N_CHUNKS    = 8;
  localparam int FILL_CAP    = 64;
  localparam int CHUNK_SPAN  = (LEDGER_SIZE / N_CHUNKS == 0) ? 1 : LEDGER_SIZE / N_CHUNKS;
  localparam int N_DIR       = 20;
  localparam int N_RAND      = 350;
  localparam int PREDICT     = -1;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT = 20000;
  localparam logic [CODE_W-1:0] CODE_SPARE = 4'd2;
  localparam logic [CODE_W-1:0] CODE_TOP   = 4'hF;

  typedef struct packed {
    in_item_t  txn;
    int        n_typed;
    out_item_t ent0;
    out_item_t ent1;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  lue_in_if  in_ch ();
  lue_out_if out_ch ();

  ledger_update_engine #(
    .ACCOUNTS(LEDGER_SIZE),
    .CHUNKS  (N_CHUNKS),
    .MAX_FILL(FILL_CAP)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  logic [BAL_W-1:0] ledger [LEDGER_SIZE];
  out_item_t        pending_entries [$];
  out_item_t        want;
  int               fault_count = 0;
  int               idle_cycles = 0;
  int               hold_left = 0;
  bit               hold_taken = 1'b0;
  bit               hold_req = 1'b0;
  bit               steady = 1'b0;

  // typed rows carry the entries read straight off the rules; others use the ledger
  dir_row_t dir_rows [N_DIR] = '{
    '{'{CODE_TRANSFER, 12'd0, CODE_TRANSFER, 12'd1, 32'd0}, 2,
      '{KIND_TRANSFER, 12'd0, 64'sd0, 3'd0, 1'b0},
      '{KIND_TRANSFER, 12'd1, 64'sd0, 3'd0, 1'b1}},
    '{'{CODE_TRANSFER, 12'd4095, CODE_TRANSFER, 12'd4095, 32'hFFFF_FFFF}, 2,
      '{KIND_TRANSFER, 12'd4095, 64'sd0, 3'd7, 1'b0},
      '{KIND_TRANSFER, 12'd4095, 64'sd0, 3'd7, 1'b1}},
    '{'{CODE_FILL, 12'd0, CODE_FILL, 12'd1, 32'hFFFF_FFFF}, 1,
      '{KIND_FILL, 12'd0, 64'sh0_FFFF_FFFF, 3'd0, 1'b1}, '0},
    '{'{CODE_TRANSFER, 12'd0, CODE_TRANSFER, 12'd4095, 32'hFFFF_FFFE}, 2,
      '{KIND_TRANSFER, 12'd0, 64'sd1, 3'd0, 1'b0},
      '{KIND_TRANSFER, 12'd4095, 64'sh0_FFFF_FFFE, 3'd7, 1'b1}},
    '{'{CODE_TRANSFER, 12'd4095, CODE_TRANSFER, 12'd4095, 32'hFFFF_FFFD}, 2,
      '{KIND_TRANSFER, 12'd4095, 64'sd1, 3'd7, 1'b0},
      '{KIND_TRANSFER, 12'd4095, 64'sh0_FFFF_FFFE, 3'd7, 1'b1}},
    '{'{CODE_TRANSFER, 12'd0, CODE_TRANSFER, 12'd2, 32'd1}, 2,
      '{KIND_TRANSFER, 12'd0, 64'sd1, 3'd0, 1'b0},
      '{KIND_TRANSFER, 12'd2, 64'sd0, 3'd0, 1'b1}},
    '{'{CODE_FILL, 12'd4095, CODE_FILL, 12'd4095, 32'd5}, 1,
      '{KIND_FILL, 12'd4095, 64'sd5, 3'd7, 1'b1}, '0},
    '{'{CODE_FILL, 12'd10, CODE_FILL, 12'd0, 32'd7}, 0, '0, '0},
    '{'{CODE_TRANSFER, 12'd3, CODE_FILL, 12'd4, 32'd9}, 0, '0, '0},
    '{'{CODE_FILL, 12'd3, CODE_TRANSFER, 12'd4, 32'd9}, 0, '0, '0},
    '{'{CODE_TOP, 12'hFFF, CODE_TOP, 12'hFFF, 32'hFFFF_FFFF}, 0, '0, '0},
    '{'{CODE_SPARE, 12'd0, CODE_SPARE, 12'd1, 32'd0}, 0, '0, '0},
    '{'{CODE_FILL, 12'd4032, CODE_FILL, 12'd4095, 32'h8000_0000}, PREDICT, '0, '0},
    '{'{CODE_FILL, 12'd500, CODE_FILL, 12'd20, 32'h1234_5678}, PREDICT, '0, '0},
    '{'{CODE_TRANSFER, 12'd505, CODE_TRANSFER, 12'd515, 32'd1000}, PREDICT, '0, '0},
    '{'{CODE_TRANSFER, 12'd515, CODE_TRANSFER, 12'd515, 32'h1234_5677}, PREDICT, '0, '0},
    '{'{CODE_FILL, 12'd0, CODE_FILL, 12'd64, 32'd0}, PREDICT, '0, '0},
    '{'{CODE_FILL, 12'd100, CODE_FILL, 12'd63, 32'd1}, PREDICT, '0, '0},
    '{'{CODE_FILL, 12'd200, CODE_FILL, 12'd65, 32'd2}, PREDICT, '0, '0},
    '{'{CODE_TRANSFER, 12'd4095, CODE_TRANSFER, 12'd0, 32'd0}, PREDICT, '0, '0}
  };

  function automatic out_item_t make_entry(input logic kind, input int acct,
                                           input logic [BAL_W-1:0] bal, input logic fin);
    out_item_t e;
    int        c;
    c = acct / CHUNK_SPAN;
    if (c > N_CHUNKS - 1) c = N_CHUNKS - 1;
    e.entry_kind = kind;
    e.account    = ACCT_W'(acct);
    e.balance    = bal;
    e.chunk      = CHUNK_W'(c);
    e.last       = fin;
    return e;
  endfunction

  // applies one transaction to the ledger and returns the write-set it produces
  function automatic void ledger_apply(input in_item_t txn, ref out_item_t ents[$]);
    logic [BAL_W-1:0] amt;
    int               src, dst, start, run;
    bit               debited;
    ents.delete();
    amt = BAL_W'(txn.amount);
    if (txn.first_code == CODE_TRANSFER && txn.second_code == CODE_TRANSFER) begin
      src = int'(txn.first_account) % LEDGER_SIZE;
      dst = int'(txn.second_value) % LEDGER_SIZE;
      debited = !ledger[src][BAL_W-1] && ledger[src] > amt;
      if (debited) ledger[src] = ledger[src] - amt;
      ents.push_back(make_entry(KIND_TRANSFER, src, ledger[src], 1'b0));
      if (debited) ledger[dst] = ledger[dst] + amt;
      ents.push_back(make_entry(KIND_TRANSFER, dst, ledger[dst], 1'b1));
    end else if (txn.first_code == CODE_FILL && txn.second_code == CODE_FILL) begin
      start = int'(txn.first_account);
      run   = int'(txn.second_value);
      if (start < LEDGER_SIZE) begin
        if (run > FILL_CAP) run = FILL_CAP;
        if (run > LEDGER_SIZE - start) run = LEDGER_SIZE - start;
        for (int i = 0; i < run; i++) begin
          ledger[start + i] = amt;
          ents.push_back(make_entry(KIND_FILL, start + i, amt, i == run - 1));
        end
      end
    end
  endfunction

  task automatic post_txn(input in_item_t txn, input int n_typed,
                          input out_item_t typed0, input out_item_t typed1);
    out_item_t fresh [$];
    in_ch.valid <= 1'b1;
    in_ch.data  <= txn;
    do @(posedge clk); while (!in_ch.ready);
    ledger_apply(txn, fresh);
    if (n_typed == PREDICT) begin
      foreach (fresh[i]) pending_entries.push_back(fresh[i]);
    end else begin
      if (n_typed > 0) pending_entries.push_back(typed0);
      if (n_typed > 1) pending_entries.push_back(typed1);
    end
    if (!steady && $urandom_range(0, 99) < 12) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // write-set receiver: random backpressure plus one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_entries.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected write-set beat: kind %0d acct %0d bal %0d chunk %0d last %0d",
                 $time, out_ch.data.entry_kind, out_ch.data.account, out_ch.data.balance,
                 out_ch.data.chunk, out_ch.data.last);
      end else begin
        want = pending_entries.pop_front();
        if (out_ch.data.entry_kind !== want.entry_kind || out_ch.data.account !== want.account ||
            out_ch.data.balance !== want.balance || out_ch.data.chunk !== want.chunk ||
            out_ch.data.last !== want.last) begin
          fault_count++;
          $display("%0t: mismatch exp kind %0d acct %0d bal %0d chunk %0d last %0d", $time,
                   want.entry_kind, want.account, want.balance, want.chunk, want.last);
          $display("%0t:          got kind %0d acct %0d bal %0d chunk %0d last %0d", $time,
                   out_ch.data.entry_kind, out_ch.data.account, out_ch.data.balance,
                   out_ch.data.chunk, out_ch.data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_item_t txn;
    int       pick;
    int       hot;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    foreach (ledger[i]) ledger[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r])
      post_txn(dir_rows[r].txn, dir_rows[r].n_typed, dir_rows[r].ent0, dir_rows[r].ent1);

    for (int k = 0; k < N_RAND; k++) begin
      if (k == 40) hold_req <= 1'b1;
      steady <= (k >= 150 && k < 230);
      pick = $urandom_range(0, 99);
      // hot accounts: the first sixteen of each chunk, so balances build up and get debited
      hot = $urandom_range(0, N_CHUNKS - 1) * CHUNK_SPAN + $urandom_range(0, 15);
      txn.amount        = $urandom();
      txn.first_account = ($urandom_range(0, 99) < 65) ? ACCT_W'(hot) : ACCT_W'($urandom());
      txn.second_value  = ($urandom_range(0, 99) < 65)
                          ? ACCT_W'($urandom_range(0, N_CHUNKS - 1) * CHUNK_SPAN
                                    + $urandom_range(0, 15))
                          : ACCT_W'($urandom());
      if (pick < 45) begin
        txn.first_code  = CODE_TRANSFER;
        txn.second_code = CODE_TRANSFER;
        pick = $urandom_range(0, 99);
        if (pick < 50) txn.amount = $urandom_range(0, 100000);
        else if (pick < 60) txn.amount = ledger[txn.first_account][AMT_W-1:0];
        else if (pick < 65) txn.amount = '0;
      end else if (pick < 80) begin
        txn.first_code  = CODE_FILL;
        txn.second_code = CODE_FILL;
        pick = $urandom_range(0, 99);
        if (pick < 80) txn.second_value = ACCT_W'($urandom_range(0, 8));
        else if (pick < 95) txn.second_value = ACCT_W'($urandom_range(9, 80));
        if ($urandom_range(0, 99) < 5)
          txn.first_account = ACCT_W'(LEDGER_SIZE - $urandom_range(1, 8));
      end else begin
        txn.first_code  = CODE_W'($urandom());
        txn.second_code = CODE_W'($urandom());
      end
      post_txn(txn, PREDICT, '0, '0);
    end
    in_ch.valid <= 1'b0;
    steady <= 1'b0;

    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_entries.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
